// ===== sv/bhpq_pkg.sv =====
// Package for the binary max-heap priority queue.
// Holds the store geometry, entry and request structs, codes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package bhpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] id;
  } entry_t;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    entry_t        data;
  } wr_req_t;

  typedef struct packed {
    logic   move;
    logic   take_right;
    entry_t winner;
  } sel_res_t;

  typedef enum logic {
    SEL_UP,
    SEL_DOWN
  } sel_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_FIN
  } state_t;

endpackage

// ===== sv/bhpq_store.sv =====
// Heap entry store: one write port and two registered read ports.
// Depends on bhpq_pkg for the entry and write request types.
`timescale 1ns / 1ps

module bhpq_store import bhpq_pkg::*; (
  input  logic          clk,
  input  wr_req_t       wr,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output entry_t        rdata_a,
  output entry_t        rdata_b
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== sv/bhpq_sel.sv =====
// Shared key compare unit for both sift directions.
// Depends on bhpq_pkg for entry, mode and result types.
`timescale 1ns / 1ps

module bhpq_sel import bhpq_pkg::*; (
  input  sel_mode_t mode,
  input  entry_t    elem,
  input  entry_t    near_e,
  input  entry_t    far_e,
  input  logic      near_ok,
  input  logic      far_ok,
  output sel_res_t  res
);

  entry_t best;

  always_comb begin
    best = elem;
    res  = '0;
    case (mode)
      SEL_UP: begin
        // The parent moves down only when its key is strictly smaller.
        res.move   = near_e.key < elem.key;
        res.winner = near_e;
      end
      SEL_DOWN: begin
        // Left child is checked first, so on equal children the left one wins.
        if (near_ok && (best.key < near_e.key)) begin
          best     = near_e;
          res.move = 1'b1;
        end
        if (far_ok && (best.key < far_e.key)) begin
          best           = far_e;
          res.move       = 1'b1;
          res.take_right = 1'b1;
        end
        res.winner = best;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// ===== sv/binary_max_heap_priority_queue_unit.sv =====
// Binary max-heap priority queue: sequencer, moving-entry registers and result register.
// A push sifts the new entry up and a pop sifts the last entry down, moving up to 10 levels;
// refused requests and the pop of the last entry go straight to the result. Each level is one store read
// and one pass through the shared compare unit. One request is in work at a time; the result
// register lets the next request enter while a result waits. Synchronous reset empties the
// queue; the store itself is not cleared. Depends on bhpq_pkg, bhpq_store and bhpq_sel.
`timescale 1ns / 1ps

module binary_max_heap_priority_queue_unit import bhpq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [31:0]        key,
  input  logic signed [31:0] entry_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        top_key,
  output logic signed [31:0] top_id,
  output logic [CW-1:0]      count,
  output logic [1:0]         status
);

  localparam logic [CW-1:0] POS_ROOT = CW'(1);
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  state_t        state, state_next;
  logic [CW-1:0] entry_count;
  logic [CW-1:0] pos;
  entry_t        elem;
  entry_t        root;
  logic [1:0]    res_status;

  wr_req_t       wr;
  logic [AW-1:0] raddr_a, raddr_b;
  entry_t        rdata_a, rdata_b;
  sel_res_t      sres;
  sel_mode_t     smode;

  logic          acc_in;
  logic          out_free;
  logic [CW-1:0] parent;
  logic [CW:0]   left_pos, right_pos;
  logic          l_ok, r_ok;

  function automatic logic [AW-1:0] slot_addr(input logic [CW:0] p);
    logic [CW:0] t;
    t = p - {{CW{1'b0}}, 1'b1};
    return t[AW-1:0];
  endfunction

  assign acc_in    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign parent    = pos >> 1;
  assign left_pos  = {pos, 1'b0};
  assign right_pos = {pos, 1'b1};
  assign l_ok      = left_pos  <= {1'b0, entry_count};
  assign r_ok      = right_pos <= {1'b0, entry_count};
  assign smode     = (state == S_UP_CMP) ? SEL_UP : SEL_DOWN;

  bhpq_store u_store (
    .clk     (clk),
    .wr      (wr),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  bhpq_sel u_sel (
    .mode    (smode),
    .elem    (elem),
    .near_e  (rdata_a),
    .far_e   (rdata_b),
    .near_ok ((smode == SEL_UP) || l_ok),
    .far_ok  ((smode == SEL_DOWN) && r_ok),
    .res     (sres)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc_in) begin
          if (kind == KIND_PUSH) begin
            state_next = (entry_count == FULL_CNT) ? S_FIN : S_UP_RD;
          end else begin
            state_next = (entry_count > POS_ROOT) ? S_DN_LAST : S_FIN;
          end
        end
      end
      S_UP_RD:   state_next = (pos == POS_ROOT) ? S_FIN : S_UP_CMP;
      S_UP_CMP:  state_next = sres.move ? S_UP_RD : S_FIN;
      S_DN_LAST: state_next = S_DN_LOAD;
      S_DN_LOAD: state_next = S_DN_CMP;
      S_DN_RD:   state_next = S_DN_CMP;
      S_DN_CMP:  state_next = sres.move ? S_DN_RD : S_FIN;
      S_FIN:     state_next = out_free ? S_IDLE : S_FIN;
      default:   state_next = S_IDLE;
    endcase
  end

  // Store port and handshake outputs.
  always_comb begin
    wr       = '0;
    in_ready = (state == S_IDLE);
    raddr_a  = slot_addr(left_pos);
    raddr_b  = slot_addr(right_pos);
    case (state)
      S_UP_RD: begin
        raddr_a = slot_addr({1'b0, parent});
        if (pos == POS_ROOT) begin
          wr.en   = 1'b1;
          wr.addr = slot_addr({1'b0, pos});
          wr.data = elem;
        end
      end
      S_UP_CMP, S_DN_CMP: begin
        // The moving entry is kept in a register; only the displaced entry is written back
        // until the moving one settles.
        wr.en   = 1'b1;
        wr.addr = slot_addr({1'b0, pos});
        wr.data = sres.move ? sres.winner : elem;
      end
      S_DN_LAST: begin
        raddr_a = slot_addr({1'b0, entry_count});
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (acc_in) begin
        if (kind == KIND_PUSH) begin
          if (entry_count != FULL_CNT) begin
            entry_count <= entry_count + POS_ROOT;
          end
        end else if (entry_count == POS_ROOT) begin
          entry_count <= '0;
        end
      end
      if (state == S_DN_LAST) begin
        entry_count <= entry_count - POS_ROOT;
      end
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (acc_in) begin
      elem       <= '{key: key, id: entry_id};
      res_status <= STATUS_OK;
      if (kind == KIND_PUSH) begin
        pos <= entry_count + POS_ROOT;
        if (entry_count == FULL_CNT) begin
          res_status <= STATUS_FULL;
        end
      end else begin
        pos <= POS_ROOT;
        if (entry_count == '0) begin
          res_status <= STATUS_EMPTY;
        end
      end
    end
    if (state == S_DN_LOAD) begin
      elem <= rdata_a;
    end
    if (((state == S_UP_CMP) || (state == S_DN_CMP)) && sres.move) begin
      if (state == S_UP_CMP) begin
        pos <= parent;
      end else begin
        pos <= sres.take_right ? right_pos[CW-1:0] : left_pos[CW-1:0];
      end
    end
    // The root is mirrored here so the result needs no extra store read.
    if (wr.en && (wr.addr == '0)) begin
      root <= wr.data;
    end
    if ((state == S_FIN) && out_free) begin
      count  <= entry_count;
      status <= res_status;
      if (entry_count == '0) begin
        top_key <= '0;
        top_id  <= '0;
      end else begin
        top_key <= root.key;
        top_id  <= $signed(root.id);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= FULL_CNT)
    else $error("entry count above capacity");

  a_full_push_keeps: assert property (@(posedge clk) disable iff (rst)
    (acc_in && (kind == KIND_PUSH) && (entry_count == FULL_CNT))
      |=> ((entry_count == $past(entry_count)) && (state == S_FIN)))
    else $error("refused push changed the queue");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> ((state != S_IDLE) && (state != S_FIN)))
    else $error("store written outside a sift");

  a_pos_valid: assert property (@(posedge clk) disable iff (rst)
    ((state == S_UP_RD) || (state == S_UP_CMP) || (state == S_DN_RD) || (state == S_DN_CMP))
      |-> ((pos != '0) && (pos <= entry_count)))
    else $error("sift position outside the heap");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (count == '0)) |-> ((top_key == '0) && (top_id == '0)))
    else $error("empty queue reports a top entry");

endmodule
